// ===== rtl/core/htwd_pkg.sv =====
// Shared types and constants for the Huffman tree-walk decoder.
// Used by the decoder top level; no dependencies.
package htwd_pkg;

    localparam int MAX_LEAVES_DEF = 256;
    localparam int IDX_W          = 9;
    localparam int SYM_W          = 8;
    localparam int TOTAL_W        = 31;
    localparam int ENTRY_W        = 1 + 2 * IDX_W + SYM_W;

    typedef enum logic [1:0] {
        REQ_NODE    = 2'd0,
        REQ_DATA    = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_UNUSED  = 2'd3
    } req_type_t;

    typedef enum logic [0:0] {
        CFG_SYMBOL_TOTAL = 1'b0,
        CFG_ROOT_INDEX   = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_STEP,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic             is_leaf;
        logic [IDX_W-1:0] one_child;
        logic [IDX_W-1:0] zero_child;
        logic [SYM_W-1:0] symbol;
    } node_t;

endpackage

// ===== rtl/core/htwd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for the decoder node table.
module htwd_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 511
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/huffman_tree_walk_decoder_top.sv =====
// Huffman tree-walk decoder top level: request decode, walk sequencer, output register.
// Depends on htwd_pkg and htwd_ram (two copies of the node table).
//
// Usage:
//   Configure symbol_total and root_index on the cfg channel (always ready).
//   Load the code tree with node requests (req_type 0), one node per request,
//   then send a restart request (req_type 2) to put the walk at the root and
//   clear the symbol count. Data requests (req_type 1) carry one compressed
//   byte each, walked MSB first, one tree step per bit.
//   Node writes, restarts and unused codes are handled in the idle state. A data
//   byte is taken in the idle state; the load state then fetches the current node
//   and the root node, the step state walks one tree step per bit (a single read
//   port on the walk copy of the table sets this) and the flush state hands over
//   the last symbol; a data byte taken once the symbol total is reached is dropped.
//   Results leave through an output register; each symbol is held back one
//   step so that last can be flagged on the final symbol of a byte.
//   When the receiver stalls, the walk holds at the next leaf until the
//   output register frees up; a new request is taken while the final result
//   of the previous byte still waits.
//   Reset clears the walk position, the count and both registers; the node
//   table holds no defined contents until written.
module huffman_tree_walk_decoder_top #(
    parameter int MAX_LEAVES = htwd_pkg::MAX_LEAVES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    req_type,
    input  logic [htwd_pkg::IDX_W-1:0]    node_index,
    input  logic                          node_is_leaf,
    input  logic [htwd_pkg::IDX_W-1:0]    node_one_child,
    input  logic [htwd_pkg::IDX_W-1:0]    node_zero_child,
    input  logic [htwd_pkg::SYM_W-1:0]    node_symbol,
    input  logic [htwd_pkg::SYM_W-1:0]    data_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [htwd_pkg::SYM_W-1:0]    symbol,
    output logic                          last,
    output logic                          done_res,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [0:0]                    cfg_index,
    input  logic [htwd_pkg::TOTAL_W-1:0]  cfg_data
);

    import htwd_pkg::*;

    localparam int DEPTH = 2 * MAX_LEAVES - 1;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(DEPTH);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   cur_node_reg, cur_node_next;
    node_t              cur_entry_reg, cur_entry_next;
    node_t              root_entry_reg, root_entry_next;
    logic [SYM_W-1:0]   byte_reg, byte_next;
    logic [2:0]         bit_cnt_reg, bit_cnt_next;
    logic [IDX_W-1:0]   next_node_reg, next_node_next;
    logic               a_oob_reg, b_oob_reg;
    logic [TOTAL_W-1:0] count_reg, count_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [IDX_W-1:0]   root_reg;
    logic               pend_v_reg, pend_v_next;
    logic [SYM_W-1:0]   pend_sym_reg, pend_sym_next;
    logic               pend_done_reg, pend_done_next;
    logic               out_valid_reg;
    logic [SYM_W-1:0]   out_sym_reg;
    logic               out_last_reg;
    logic               out_done_reg;

    logic               in_acc;
    logic               wr_en;
    node_t              wr_node;
    logic               ra_en, rb_en;
    logic [IDX_W-1:0]   ra_idx, rb_idx;
    logic [ENTRY_W-1:0] rd_a, rd_b;
    node_t              rd_a_node, rd_b_node;
    node_t              nentry;
    node_t              step_entry;
    logic [IDX_W-1:0]   sel_idx;
    logic               out_free;
    logic               out_load;
    logic               out_last_n;
    logic               stall;
    logic               step_leaf;
    logic [TOTAL_W-1:0] count_inc;

    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign count_inc = count_reg + TOTAL_W'(1);

    assign wr_en   = in_acc && (req_type == REQ_NODE) && (node_index < DEPTH_IDX);
    assign wr_node = '{is_leaf:    node_is_leaf,
                       one_child:  node_one_child,
                       zero_child: node_zero_child,
                       symbol:     node_symbol};

    htwd_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_walk (
        .clk   (clk),
        .we    (wr_en),
        .waddr (node_index[AW-1:0]),
        .wdata (wr_node),
        .re    (ra_en),
        .raddr (ra_idx[AW-1:0]),
        .rdata (rd_a)
    );

    htwd_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_root (
        .clk   (clk),
        .we    (wr_en),
        .waddr (node_index[AW-1:0]),
        .wdata (wr_node),
        .re    (rb_en),
        .raddr (rb_idx[AW-1:0]),
        .rdata (rd_b)
    );

    assign rd_a_node = a_oob_reg ? node_t'('0) : node_t'(rd_a);
    assign rd_b_node = b_oob_reg ? node_t'('0) : node_t'(rd_b);
    assign nentry    = rd_a_node;
    assign stall     = nentry.is_leaf && pend_v_reg && !out_free;
    assign step_leaf = (state_reg == ST_STEP) && nentry.is_leaf && !stall;

    always_comb
    begin
        state_next      = state_reg;
        cur_node_next   = cur_node_reg;
        cur_entry_next  = cur_entry_reg;
        root_entry_next = root_entry_reg;
        byte_next       = byte_reg;
        bit_cnt_next    = bit_cnt_reg;
        next_node_next  = next_node_reg;
        count_next      = count_reg;
        pend_v_next     = pend_v_reg;
        pend_sym_next   = pend_sym_reg;
        pend_done_next  = pend_done_reg;
        in_ready        = 1'b0;
        ra_en           = 1'b0;
        ra_idx          = cur_node_reg;
        rb_en           = 1'b0;
        rb_idx          = root_reg;
        out_load        = 1'b0;
        out_last_n      = 1'b0;
        step_entry      = cur_entry_reg;
        sel_idx         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (req_type_t'(req_type))
                        REQ_RESTART:
                        begin
                            cur_node_next = root_reg;
                            count_next    = '0;
                        end
                        REQ_DATA:
                        begin
                            if (count_reg < total_reg)
                            begin
                                ra_en        = 1'b1;
                                rb_en        = 1'b1;
                                byte_next    = data_byte;
                                bit_cnt_next = 3'd7;
                                state_next   = ST_LOAD;
                            end
                        end
                        REQ_NODE, REQ_UNUSED:
                        begin
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                cur_entry_next  = rd_a_node;
                root_entry_next = rd_b_node;
                sel_idx         = byte_reg[bit_cnt_reg] ? rd_a_node.one_child
                                                        : rd_a_node.zero_child;
                ra_en           = 1'b1;
                ra_idx          = sel_idx;
                next_node_next  = sel_idx;
                state_next      = ST_STEP;
            end
            ST_STEP:
            begin
                if (!stall)
                begin
                    if (nentry.is_leaf)
                    begin
                        count_next     = count_inc;
                        pend_v_next    = 1'b1;
                        pend_sym_next  = nentry.symbol;
                        pend_done_next = (count_inc == total_reg);
                        out_load       = pend_v_reg;
                        cur_node_next  = root_reg;
                        step_entry     = root_entry_reg;
                    end
                    else
                    begin
                        cur_node_next = next_node_reg;
                        step_entry    = nentry;
                    end
                    cur_entry_next = step_entry;
                    if ((bit_cnt_reg == 3'd0) || (nentry.is_leaf && (count_inc >= total_reg)))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        bit_cnt_next   = bit_cnt_reg - 3'd1;
                        sel_idx        = byte_reg[bit_cnt_reg - 3'd1] ? step_entry.one_child
                                                                      : step_entry.zero_child;
                        ra_en          = 1'b1;
                        ra_idx         = sel_idx;
                        next_node_next = sel_idx;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_v_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_load    = 1'b1;
                    out_last_n  = 1'b1;
                    pend_v_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_node_reg  <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            root_reg      <= '0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_node_reg <= cur_node_next;
            count_reg    <= count_next;
            pend_v_reg   <= pend_v_next;
            if (cfg_valid)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_SYMBOL_TOTAL: total_reg <= cfg_data;
                    CFG_ROOT_INDEX:   root_reg  <= cfg_data[IDX_W-1:0];
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_entry_reg  <= cur_entry_next;
        root_entry_reg <= root_entry_next;
        byte_reg       <= byte_next;
        bit_cnt_reg    <= bit_cnt_next;
        next_node_reg  <= next_node_next;
        pend_sym_reg   <= pend_sym_next;
        pend_done_reg  <= pend_done_next;
        if (ra_en)
        begin
            a_oob_reg <= (ra_idx >= DEPTH_IDX);
        end
        if (rb_en)
        begin
            b_oob_reg <= (rb_idx >= DEPTH_IDX);
        end
        if (out_load)
        begin
            out_sym_reg  <= pend_sym_reg;
            out_last_reg <= out_last_n;
            out_done_reg <= pend_done_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign symbol    = out_sym_reg;
    assign last      = out_last_reg;
    assign done_res  = out_done_reg;

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_v_reg)
        else $error("symbol still pending while idle");

    a_flush_empty_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && !pend_v_reg) |=> (state_reg == ST_IDLE))
        else $error("flush with nothing pending did not return to idle");

    a_leaf_counts: assert property (@(posedge clk) disable iff (!rst_n)
        step_leaf |=> (pend_v_reg && (count_reg == $past(count_reg) + TOTAL_W'(1))))
        else $error("leaf step did not register a symbol and bump the count");

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (step_leaf && pend_v_reg) |-> out_free)
        else $error("result pushed into a busy output register");

endmodule
